[rtl/core/mesh_forwarding_engine_defines.svh]
// Assertion macros used by the checker file.
`ifndef MESH_FORWARDING_ENGINE_DEFINES_SVH
`define MESH_FORWARDING_ENGINE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MFE_ASSERT_IMPL(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define MFE_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);
`endif

[rtl/core/mfe_pkg.sv]
`timescale 1ns / 1ps
package mfe_pkg;
	localparam int TrackerEntriesDefault = 128;
	localparam int PortCountDefault = 8;
	localparam int RouteEntries = 256;

	typedef enum logic [2:0] {
		OP_DATA = 3'd0, OP_ACK = 3'd1, OP_TICK = 3'd2, OP_DOWN = 3'd3, OP_UP = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE = 3'd0, ACT_ACK_SOURCE = 3'd1, ACT_ROUTED = 3'd2, ACT_FLOODED = 3'd3,
		ACT_ACK_FORWARD = 3'd4, ACT_DUPLICATE = 3'd5, ACT_UNKNOWN_ACK = 3'd6
	} act_t;

	localparam logic CFG_NODE_ADDRESS = 1'b0;
	localparam logic CFG_TIMEOUT_TICKS = 1'b1;

	typedef struct packed {
		logic [2:0] operation;
		logic [15:0] packet_id;
		logic [7:0] target_address;
		logic [2:0] port;
	} in_item_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] port_mask;
		logic [7:0] lost_count;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_TICK_RD, ST_TICK_WR,
		ST_DOWN_RD, ST_DOWN_WR, ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic clr_step;
		logic rd_slot;
		logic decide;
		logic tick_rd;
		logic tick_wr;
		logic down_rd;
		logic down_wr;
		logic idx_inc;
		logic idx_clr;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic trk_last;
		logic rt_last;
		logic is_tick;
		logic is_down;
	} sts_t;
endpackage

[rtl/core/mesh_forwarding_engine.sv]
`timescale 1ns / 1ps
// Data, ack, link up and ignored items pass the read and decide states, then offer a result.
// Tick: after the read state, a read and a write per tracker slot, then the result.
// Link down: after the read state, a read and a write per route table entry, then the result.
// One item at a time; the next is accepted in idle, once the result has left.
// Reset clears control state, then a pass clears all 256 route table entries.
module mesh_forwarding_engine import mfe_pkg::*; #(
	parameter int TRACKER_ENTRIES = TrackerEntriesDefault,
	parameter int PORT_COUNT = PortCountDefault
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [7:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mfe_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	mfe_dpath #(.TRACKER_ENTRIES(TRACKER_ENTRIES), .PORT_COUNT(PORT_COUNT)) u_dpath (
		.clk, .arst_n, .in_item(in_data), .cfg_we(cfg_valid), .cfg_sel(cfg_index),
		.cfg_data, .cmd, .sts, .out_item(out_data)
	);
endmodule

[rtl/core/mfe_ctrl.sv]
`timescale 1ns / 1ps
module mfe_ctrl import mfe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.rt_last) state_nx = ST_IDLE;
			ST_IDLE: if (in_valid) state_nx = ST_READ;
			ST_READ: begin
				if (sts.is_tick) state_nx = ST_TICK_RD;
				else if (sts.is_down) state_nx = ST_DOWN_RD;
				else state_nx = ST_DECIDE;
			end
			ST_DECIDE: state_nx = ST_OUT;
			ST_TICK_RD: state_nx = ST_TICK_WR;
			ST_TICK_WR: state_nx = sts.trk_last ? ST_OUT : ST_TICK_RD;
			ST_DOWN_RD: state_nx = ST_DOWN_WR;
			ST_DOWN_WR: state_nx = sts.rt_last ? ST_OUT : ST_DOWN_RD;
			ST_OUT: if (!out_stall) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load_item = in_valid;
				cmd.idx_clr = 1'b1;
			end
			ST_READ: cmd.rd_slot = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_TICK_RD: cmd.tick_rd = 1'b1;
			ST_TICK_WR: begin
				cmd.tick_wr = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ST_DOWN_RD: cmd.down_rd = 1'b1;
			ST_DOWN_WR: begin
				cmd.down_wr = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
		cmd.out_load = (state_q == ST_DECIDE) ||
			(state_q == ST_TICK_WR && sts.trk_last) ||
			(state_q == ST_DOWN_WR && sts.rt_last) ||
			(state_q == ST_READ && (sts.is_tick || sts.is_down) && 1'b0);
	end
endmodule

[rtl/core/mfe_dpath.sv]
`timescale 1ns / 1ps
module mfe_dpath import mfe_pkg::*; #(
	parameter int TRACKER_ENTRIES = TrackerEntriesDefault,
	parameter int PORT_COUNT = PortCountDefault
) (
	input logic clk,
	input logic arst_n,
	input in_item_t in_item,
	input logic cfg_we,
	input logic cfg_sel,
	input logic [7:0] cfg_data,
	input cmd_t cmd,
	output sts_t sts,
	output out_item_t out_item
);
	localparam int TW = $clog2(TRACKER_ENTRIES);
	localparam int IW = (TW > 8) ? TW : 8;
	localparam logic [7:0] PortAll = 8'((9'd1 << PORT_COUNT) - 9'd1);

	// Tracker flags live in flip-flops (reset), payload in a memory.
	logic [TRACKER_ENTRIES-1:0] trk_written_q, trk_active_q;
	logic [15:0] trk_id_mem [TRACKER_ENTRIES];
	logic [7:0] trk_tgt_mem [TRACKER_ENTRIES];
	logic [2:0] trk_src_mem [TRACKER_ENTRIES];
	logic [7:0] trk_age_mem [TRACKER_ENTRIES];
	// Route valid and port share one memory word, cleared by a pass after reset.
	logic [3:0] route_mem [RouteEntries];

	logic [7:0] node_q, timeout_q, active_q;
	in_item_t item_q;
	logic [IW:0] idx_q;
	logic [TW-1:0] slot;
	logic [15:0] rd_id_q;
	logic [7:0] rd_tgt_q, rd_age_q;
	logic [2:0] rd_src_q;
	logic rd_wr_q, rd_act_q;
	logic [3:0] rd_route_q;
	logic [7:0] lost_q;
	out_item_t res_q;
	logic [7:0] tmo;
	logic port_ok, hit;
	logic [7:0] in_bit, age_nx;
	logic [2:0] act_c;
	logic [7:0] mask_c;
	logic rt_we;
	logic [7:0] rt_waddr;
	logic [3:0] rt_wdata;
	logic [7:0] rt_raddr;

	assign slot = item_q.packet_id[TW-1:0];
	assign tmo = (timeout_q == 8'd0) ? 8'd1 : timeout_q;
	assign port_ok = ({1'b0, item_q.port} < 4'(PORT_COUNT));
	assign in_bit = (8'd1 << item_q.port) & PortAll;
	assign hit = rd_wr_q && (rd_id_q == item_q.packet_id);
	assign age_nx = (rd_age_q == 8'hFF) ? rd_age_q : rd_age_q + 8'd1;

	assign sts.trk_last = (idx_q[TW-1:0] == TW'(TRACKER_ENTRIES - 1));
	assign sts.rt_last = (idx_q[7:0] == 8'hFF);
	assign sts.is_tick = (item_q.operation == OP_TICK);
	assign sts.is_down = (item_q.operation == OP_DOWN) && port_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= 8'd0;
			timeout_q <= 8'd1;
		end else if (cfg_we) begin
			if (cfg_sel == CFG_NODE_ADDRESS) node_q <= cfg_data;
			else timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= in_item;
	end

	// Route read address: the sweep index during link down, else the target of the item.
	always_comb begin
		priority if (cmd.down_rd) rt_raddr = idx_q[7:0];
		else rt_raddr = item_q.target_address;
	end

	always_ff @(posedge clk) begin
		rd_route_q <= route_mem[rt_raddr];
		if (cmd.rd_slot || cmd.tick_rd) begin
			rd_id_q <= trk_id_mem[cmd.tick_rd ? idx_q[TW-1:0] : slot];
			rd_tgt_q <= trk_tgt_mem[cmd.tick_rd ? idx_q[TW-1:0] : slot];
			rd_src_q <= trk_src_mem[cmd.tick_rd ? idx_q[TW-1:0] : slot];
			rd_age_q <= trk_age_mem[cmd.tick_rd ? idx_q[TW-1:0] : slot];
			rd_wr_q <= trk_written_q[cmd.tick_rd ? idx_q[TW-1:0] : slot];
			rd_act_q <= trk_active_q[cmd.tick_rd ? idx_q[TW-1:0] : slot];
		end
	end

	always_comb begin
		act_c = ACT_NONE;
		mask_c = 8'd0;
		if (port_ok) begin
			unique case (item_q.operation)
				OP_DATA: begin
					if (item_q.target_address == node_q) begin
						act_c = ACT_ACK_SOURCE;
						mask_c = in_bit;
					end else if (hit) begin
						act_c = ACT_DUPLICATE;
					end else if (rd_route_q[3]) begin
						act_c = ACT_ROUTED;
						mask_c = (8'd1 << rd_route_q[2:0]) & PortAll;
					end else begin
						act_c = ACT_FLOODED;
						mask_c = active_q & ~in_bit & PortAll;
					end
				end
				OP_ACK: begin
					if (hit) begin
						act_c = ACT_ACK_FORWARD;
						mask_c = (8'd1 << rd_src_q) & PortAll;
					end else begin
						act_c = ACT_UNKNOWN_ACK;
					end
				end
				default: ;
			endcase
		end
	end

	logic data_store, ack_hit, expire;
	assign data_store = cmd.decide && port_ok && item_q.operation == OP_DATA &&
		item_q.target_address != node_q && !hit;
	assign ack_hit = cmd.decide && port_ok && item_q.operation == OP_ACK && hit;
	assign expire = cmd.tick_wr && rd_act_q && (age_nx >= tmo);

	// Single route write port: clear sweep, learning, expiry, link down.
	always_comb begin
		rt_we = 1'b0;
		rt_waddr = idx_q[7:0];
		rt_wdata = 4'd0;
		priority if (cmd.clr_step) begin
			rt_we = 1'b1;
		end else if (ack_hit) begin
			rt_we = 1'b1;
			rt_waddr = rd_tgt_q;
			rt_wdata = {1'b1, item_q.port};
		end else if (expire) begin
			rt_we = 1'b1;
			rt_waddr = rd_tgt_q;
		end else if (cmd.down_wr) begin
			rt_we = rd_route_q[3] && (rd_route_q[2:0] == item_q.port);
		end
	end

	always_ff @(posedge clk) begin
		if (rt_we) route_mem[rt_waddr] <= rt_wdata;
	end

	always_ff @(posedge clk) begin
		if (data_store) begin
			trk_id_mem[slot] <= item_q.packet_id;
			trk_tgt_mem[slot] <= item_q.target_address;
			trk_src_mem[slot] <= item_q.port;
			trk_age_mem[slot] <= 8'd0;
		end else if (cmd.tick_wr && rd_act_q) begin
			trk_age_mem[idx_q[TW-1:0]] <= age_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_written_q <= '0;
			trk_active_q <= '0;
			active_q <= 8'd0;
			lost_q <= 8'd0;
		end else begin
			if (cmd.load_item) lost_q <= 8'd0;
			if (data_store) begin
				trk_written_q[slot] <= 1'b1;
				trk_active_q[slot] <= 1'b1;
			end
			if (ack_hit) trk_active_q[slot] <= 1'b0;
			if (expire) begin
				trk_active_q[idx_q[TW-1:0]] <= 1'b0;
				if (lost_q != 8'hFF) lost_q <= lost_q + 8'd1;
			end
			if (cmd.decide && port_ok && item_q.operation == OP_UP)
				active_q <= active_q | in_bit;
			if (cmd.down_rd && idx_q[7:0] == 8'd0)
				active_q <= active_q & ~in_bit;
		end
	end

	logic [7:0] lost_fin;
	assign lost_fin = (expire && lost_q != 8'hFF) ? lost_q + 8'd1 : lost_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.action <= cmd.decide ? act_c : ACT_NONE;
			res_q.port_mask <= cmd.decide ? mask_c : 8'd0;
			res_q.lost_count <= cmd.tick_wr ? lost_fin : 8'd0;
		end
	end

	assign out_item = res_q;
endmodule

[rtl/core/mfe_checker.sv]
`timescale 1ns / 1ps
`include "mesh_forwarding_engine_defines.svh"
module mfe_checker import mfe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_item_t out_data
);
	`MFE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, $stable(out_data), "output item changed while stalled")
	`MFE_ASSERT_IMPL(a_one_side, clk, arst_n, out_valid, in_stall, "input taken while result pending")
	`MFE_ASSERT_IMPL(a_mask_zero, clk, arst_n, out_valid && (out_data.action == ACT_NONE || out_data.action == ACT_DUPLICATE || out_data.action == ACT_UNKNOWN_ACK), out_data.port_mask == 8'd0, "drop with nonzero mask")
	`MFE_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall && !out_valid, "no processing after accept")
endmodule

bind mesh_forwarding_engine mfe_checker u_mfe_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

[verif/tb_mesh_forwarding_engine.sv]
`timescale 1ns / 1ps
module tb_mesh_forwarding_engine;
	import mfe_pkg::*;

	// Forwarding decisions kept in step with the block, one expectation per item.
	class forwarding_scoreboard;
		logic [7:0] node_addr;
		logic [7:0] timeout;
		bit trk_written[128];
		bit trk_active[128];
		logic [15:0] trk_id[128];
		logic [7:0] trk_target[128];
		logic [2:0] trk_src[128];
		logic [7:0] trk_age[128];
		bit rt_valid[256];
		logic [2:0] rt_port[256];
		logic [7:0] up_ports;
		out_item_t pending[$];
		int errors;

		function void clear();
			node_addr = 0;
			timeout = 1;
			up_ports = 0;
			errors = 0;
			foreach (trk_written[i]) begin
				trk_written[i] = 0;
				trk_active[i] = 0;
			end
			foreach (rt_valid[i]) rt_valid[i] = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [7:0] value);
			if (idx == CFG_NODE_ADDRESS) node_addr = value;
			else timeout = value;
		endfunction

		function void note_item(in_item_t it);
			out_item_t r;
			int slot;
			int lost;
			logic [7:0] pb;
			r = '0;
			lost = 0;
			slot = it.packet_id % 128;
			pb = 8'(1) << it.port;
			if (it.operation == OP_TICK) begin
				for (int i = 0; i < 128; i++) begin
					if (!trk_active[i]) continue;
					if (trk_age[i] != 8'hff) trk_age[i]++;
					if (trk_age[i] >= timeout) begin
						trk_active[i] = 0;
						rt_valid[trk_target[i]] = 0;
						if (lost < 255) lost++;
					end
				end
				r.action = ACT_NONE;
				r.lost_count = 8'(lost);
			end else if (it.operation == OP_DATA) begin
				if (it.target_address == node_addr) begin
					r.action = ACT_ACK_SOURCE;
					r.port_mask = pb;
				end else if (trk_written[slot] && trk_id[slot] == it.packet_id) begin
					r.action = ACT_DUPLICATE;
				end else begin
					trk_written[slot] = 1;
					trk_active[slot] = 1;
					trk_id[slot] = it.packet_id;
					trk_target[slot] = it.target_address;
					trk_src[slot] = it.port;
					trk_age[slot] = 0;
					if (rt_valid[it.target_address]) begin
						r.action = ACT_ROUTED;
						r.port_mask = 8'(1) << rt_port[it.target_address];
					end else begin
						r.action = ACT_FLOODED;
						r.port_mask = up_ports & ~pb;
					end
				end
			end else if (it.operation == OP_ACK) begin
				if (trk_written[slot] && trk_id[slot] == it.packet_id) begin
					trk_active[slot] = 0;
					r.action = ACT_ACK_FORWARD;
					r.port_mask = 8'(1) << trk_src[slot];
					rt_valid[trk_target[slot]] = 1;
					rt_port[trk_target[slot]] = it.port;
				end else begin
					r.action = ACT_UNKNOWN_ACK;
				end
			end else if (it.operation == OP_DOWN) begin
				up_ports = up_ports & ~pb;
				for (int i = 0; i < 256; i++)
					if (rt_valid[i] && rt_port[i] == it.port) rt_valid[i] = 0;
			end else if (it.operation == OP_UP) begin
				up_ports = up_ports | pb;
			end
			pending.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (pending.size() == 0) begin
				$error("result with no expectation: %h", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.action !== exp.action) begin
				$error("action expected %0d actual %0d", exp.action, got.action);
				errors++;
			end
			if (got.port_mask !== exp.port_mask) begin
				$error("port_mask expected %h actual %h", exp.port_mask, got.port_mask);
				errors++;
			end
			if (got.lost_count !== exp.lost_count) begin
				$error("lost_count expected %0d actual %0d", exp.lost_count, got.lost_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;

	forwarding_scoreboard board;
	bit hold_results;
	bit stress_stall;
	logic [15:0] recent_ids[$];

	mesh_forwarding_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#300ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic int short_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// Receiver: random stalls, plus a long hold-off when asked.
	always @(negedge clk) begin
		if (!arst_n) out_stall <= 0;
		else if (hold_results) out_stall <= 1;
		else if (stress_stall) out_stall <= ($urandom_range(0, 3) != 0);
		else out_stall <= ($urandom_range(0, 9) < 2);
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall) board.check_result(out_data);

	task automatic idle_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	task automatic send_item(logic [2:0] op, logic [15:0] id, logic [7:0] tgt, logic [2:0] p);
		in_item_t it;
		it.operation = op;
		it.packet_id = id;
		it.target_address = tgt;
		it.port = p;
		@(negedge clk);
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_item(it);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic send_gapped(logic [2:0] op, logic [15:0] id, logic [7:0] tgt, logic [2:0] p);
		send_item(op, id, tgt, p);
		idle_cycles(short_gap());
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (board.pending.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		// A link-down sweep is the longest job.
		idle_cycles(600);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// Mostly well-formed traffic: data, acks mostly for recent ids, ticks, link up/down, bad ops.
	task automatic random_traffic(int count, int tick_weight);
		logic [15:0] id;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				id = (pick < 8 && recent_ids.size() > 0) ?
					recent_ids[$urandom_range(0, recent_ids.size() - 1)] : 16'($urandom);
				recent_ids.push_back(id);
				if (recent_ids.size() > 24) void'(recent_ids.pop_front());
				send_gapped(OP_DATA, id,
					($urandom_range(0, 9) == 0) ? board.node_addr : 8'($urandom_range(0, 15)),
					3'($urandom_range(0, 7)));
			end else if (pick < 70) begin
				id = (recent_ids.size() > 0 && $urandom_range(0, 4) != 0) ?
					recent_ids[$urandom_range(0, recent_ids.size() - 1)] : 16'($urandom);
				send_gapped(OP_ACK, id, 8'($urandom), 3'($urandom_range(0, 7)));
			end else if (pick < 70 + tick_weight) begin
				send_gapped(OP_TICK, 16'($urandom), 8'($urandom), 3'($urandom));
			end else if (pick < 88) begin
				send_gapped(OP_UP, 16'($urandom), 8'($urandom), 3'($urandom_range(0, 7)));
			end else if (pick < 91) begin
				send_gapped(OP_DOWN, 16'($urandom), 8'($urandom), 3'($urandom_range(0, 7)));
			end else begin
				send_gapped(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom),
					3'($urandom));
			end
		end
	endtask

	initial begin
		board = new();
		board.clear();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		hold_results = 0;
		stress_stall = 0;
		out_stall = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		write_reg(CFG_NODE_ADDRESS, 8'h00);
		write_reg(CFG_TIMEOUT_TICKS, 8'd1);
		// Directed: link events, flooding, ack learning, routing, duplicates, aging.
		send_item(OP_UP, 16'h0000, 8'h00, 3'd0);
		send_item(OP_UP, 16'hffff, 8'hff, 3'd7);
		send_item(OP_UP, 16'h1234, 8'h00, 3'd3);
		send_item(OP_UP, 16'h1234, 8'h00, 3'd3);
		send_item(OP_DATA, 16'h0000, 8'h00, 3'd5);
		send_item(OP_DATA, 16'hffff, 8'hff, 3'd0);
		send_item(OP_DATA, 16'hffff, 8'hff, 3'd3);
		send_item(OP_ACK, 16'hffff, 8'h00, 3'd7);
		send_item(OP_ACK, 16'hffff, 8'h00, 3'd3);
		send_item(OP_DATA, 16'h007f, 8'hff, 3'd7);
		send_item(OP_ACK, 16'h5555, 8'haa, 3'd1);
		send_item(OP_DATA, 16'haaaa, 8'h55, 3'd2);
		send_item(OP_TICK, 16'h0000, 8'h00, 3'd0);
		send_item(OP_TICK, 16'hffff, 8'hff, 3'd7);
		send_item(OP_DOWN, 16'h0000, 8'h00, 3'd3);
		send_item(OP_DATA, 16'h0100, 8'hff, 3'd1);
		send_item(OP_DOWN, 16'h0000, 8'h00, 3'd3);
		send_item(3'd5, 16'hffff, 8'hff, 3'd7);
		send_item(3'd7, 16'h0000, 8'h00, 3'd0);
		drain();

		write_reg(CFG_NODE_ADDRESS, 8'hff);
		write_reg(CFG_TIMEOUT_TICKS, 8'd255);
		for (int k = 0; k < 130; k++)
			send_item(OP_DATA, 16'(k * 3 + 1), 8'(k), 3'(k));
		random_traffic(300, 6);
		drain();

		write_reg(CFG_NODE_ADDRESS, 8'h05);
		write_reg(CFG_TIMEOUT_TICKS, 8'd3);
		random_traffic(450, 8);

		// Long receiver hold-off while the sender keeps offering items.
		fork
			begin
				hold_results = 1;
				repeat (300) @(negedge clk);
				hold_results = 0;
			end
			random_traffic(20, 0);
		join
		drain();

		write_reg(CFG_NODE_ADDRESS, 8'h0a);
		write_reg(CFG_TIMEOUT_TICKS, 8'd0);
		stress_stall = 1;
		random_traffic(250, 6);
		stress_stall = 0;
		drain();

		write_reg(CFG_NODE_ADDRESS, 8'h80);
		write_reg(CFG_TIMEOUT_TICKS, 8'd2);
		random_traffic(450, 7);
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

[mesh_forwarding_engine.f]
+incdir+rtl/core
rtl/core/mfe_pkg.sv
rtl/core/mfe_ctrl.sv
rtl/core/mfe_dpath.sv
rtl/core/mesh_forwarding_engine.sv
rtl/core/mfe_checker.sv
verif/tb_mesh_forwarding_engine.sv
